// ----- rtl/core/deq_pkg.sv -----
// shared types and constants for the double-ended queue
`default_nettype none

package deq_pkg;

    localparam int DEPTH       = 16;
    localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int WORD_W      = 32;
    localparam int CMD_W       = 3;
    localparam int COUNT_OUT_W = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [WORD_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] popped_value;
        status_t                  status;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] back_value;
        logic                     is_empty;
        logic [COUNT_OUT_W-1:0]   entry_count;
    } rsp_t;

    typedef struct packed {
        logic exec;
        logic capture;
    } ctl_cmd_t;

    typedef struct packed {
        logic need_read;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/deq_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/deq_ctrl.sv -----
// sequencer for the double-ended queue
`default_nettype none

module deq_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    input  wire deq_pkg::dp_status_t dp_status,
    output deq_pkg::ctl_cmd_t        ctl
);

    deq_pkg::state_t state_reg;
    deq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= deq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            deq_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = dp_status.need_read ? deq_pkg::S_READ : deq_pkg::S_RESP;
                end
            end
            deq_pkg::S_READ:
            begin
                state_next = deq_pkg::S_RESP;
            end
            deq_pkg::S_RESP:
            begin
                if (rsp_ready)
                begin
                    state_next = deq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = deq_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready   = 1'b0;
        rsp_valid   = 1'b0;
        ctl.exec    = 1'b0;
        ctl.capture = 1'b0;
        unique case (state_reg)
            deq_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                ctl.exec  = req_valid;
            end
            deq_pkg::S_READ:
            begin
                ctl.capture = 1'b1;
            end
            deq_pkg::S_RESP:
            begin
                rsp_valid = 1'b1;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/deq_dp.sv -----
// pointers, cached end words and slot ram of the double-ended queue
`default_nettype none

module deq_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire deq_pkg::req_t     req,
    input  wire deq_pkg::ctl_cmd_t ctl,
    output deq_pkg::dp_status_t    dp_status,
    output deq_pkg::rsp_t          rsp
);

    localparam logic [deq_pkg::ADDR_W-1:0] LAST_IDX  = deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1);
    localparam logic [deq_pkg::CNT_W-1:0]  FULL_CNT  = deq_pkg::CNT_W'(deq_pkg::DEPTH);
    localparam logic [deq_pkg::CNT_W-1:0]  ONE_CNT   = deq_pkg::CNT_W'(1);

    logic [deq_pkg::ADDR_W-1:0] head_reg, head_next;
    logic [deq_pkg::ADDR_W-1:0] tail_reg, tail_next;
    logic [deq_pkg::CNT_W-1:0]  count_reg, count_next;
    logic signed [deq_pkg::WORD_W-1:0] front_reg, front_next;
    logic signed [deq_pkg::WORD_W-1:0] back_reg, back_next;
    logic signed [deq_pkg::WORD_W-1:0] popped_reg, popped_next;
    deq_pkg::status_t status_reg, status_next;
    logic rd_front_reg, rd_front_next;

    logic [deq_pkg::ADDR_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
    logic [deq_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [deq_pkg::WORD_W-1:0] ram_rdata;
    logic ram_we;
    logic is_push_front, is_push_back, is_pop_front, is_pop_back;
    logic empty, full;

    always_comb
    begin
        head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
        head_dec = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
        tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
        tail_dec = (tail_reg == '0) ? LAST_IDX : tail_reg - 1'b1;

        is_push_front = (req.cmd == deq_pkg::CMD_PUSH_FRONT);
        is_push_back  = (req.cmd == deq_pkg::CMD_PUSH_BACK);
        is_pop_front  = (req.cmd == deq_pkg::CMD_POP_FRONT);
        is_pop_back   = (req.cmd == deq_pkg::CMD_POP_BACK);
        empty         = (count_reg == '0);
        full          = (count_reg == FULL_CNT);

        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        front_next    = front_reg;
        back_next     = back_reg;
        popped_next   = '0;
        status_next   = deq_pkg::ST_OK;
        rd_front_next = rd_front_reg;
        ram_we        = 1'b0;
        ram_waddr     = head_dec;
        ram_raddr     = head_inc;
        dp_status.need_read = 1'b0;

        if (is_push_front || is_push_back)
        begin
            if (full)
            begin
                status_next = deq_pkg::ST_OVERFLOW;
            end
            else
            begin
                ram_we     = ctl.exec;
                count_next = count_reg + ONE_CNT;
                if (is_push_front)
                begin
                    head_next  = head_dec;
                    ram_waddr  = head_dec;
                    front_next = req.value;
                    if (empty)
                    begin
                        back_next = req.value;
                    end
                end
                else
                begin
                    tail_next = tail_inc;
                    ram_waddr = tail_inc;
                    back_next = req.value;
                    if (empty)
                    begin
                        front_next = req.value;
                    end
                end
            end
        end
        else if (is_pop_front || is_pop_back)
        begin
            if (empty)
            begin
                status_next = deq_pkg::ST_UNDERFLOW;
            end
            else
            begin
                count_next          = count_reg - ONE_CNT;
                dp_status.need_read = (count_reg != ONE_CNT);
                if (is_pop_front)
                begin
                    popped_next   = front_reg;
                    head_next     = head_inc;
                    ram_raddr     = head_inc;
                    rd_front_next = 1'b1;
                end
                else
                begin
                    popped_next   = back_reg;
                    tail_next     = tail_dec;
                    ram_raddr     = tail_dec;
                    rd_front_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= LAST_IDX;
            count_reg <= '0;
        end
        else if (ctl.exec)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            front_reg    <= front_next;
            back_reg     <= back_next;
            popped_reg   <= popped_next;
            status_reg   <= status_next;
            rd_front_reg <= rd_front_next;
        end
        else if (ctl.capture)
        begin
            if (rd_front_reg)
            begin
                front_reg <= ram_rdata;
            end
            else
            begin
                back_reg <= ram_rdata;
            end
        end
    end

    deq_ram #(
        .WIDTH (deq_pkg::WORD_W),
        .DEPTH (deq_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req.value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        rsp.popped_value = popped_reg;
        rsp.status       = status_reg;
        rsp.front_value  = empty ? '0 : front_reg;
        rsp.back_value   = empty ? '0 : back_reg;
        rsp.is_empty     = empty;
        rsp.entry_count  = deq_pkg::COUNT_OUT_W'(count_reg);
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> (tail_reg == head_dec))
        else $error("pointers inconsistent while empty");

    a_overflow_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.exec && full && (is_push_front || is_push_back)) |=> $stable(count_reg))
        else $error("count moved on dropped push");

    a_no_write_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (is_pop_front || is_pop_back) |-> !ram_we)
        else $error("ram write during pop");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/double_ended_queue_top.sv -----
// top level of the bounded double-ended queue
// usage:
//   req channel (req_valid/req_ready/req) carries one command per transaction:
//   push front, push back, pop front, pop back or query, plus the word to push.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns one result per command: the
//   popped word, status, front and back words, empty flag and entry count.
//   one command is in flight at a time; req_ready is high only while idle.
//   the result is registered and valid in the cycle after acceptance, or,
//   after a pop that leaves entries, once a read state has passed, since the
//   new end word comes from the slot ram through its registered read port.
//   the next command waits until the previous result is taken, as the
//   sequencer handles one command at a time.
//   a stalled rsp_ready holds the result and keeps req_ready low.
//   reset empties the queue (head and count to zero, tail to the last slot)
//   and returns to idle; slots are not cleared and are never shown unwritten.
`default_nettype none

module double_ended_queue_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire deq_pkg::req_t  req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output deq_pkg::rsp_t       rsp
);

    deq_pkg::ctl_cmd_t   ctl;
    deq_pkg::dp_status_t dp_status;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .dp_status (dp_status),
        .ctl       (ctl)
    );

    deq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ctl       (ctl),
        .dp_status (dp_status),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// self-checking testbench for double_ended_queue_top with a ring buffer predictor
module tb;

    localparam logic [deq_pkg::CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
    localparam logic [deq_pkg::CMD_W-1:0] CMD_SPARE_MID = 3'd6;
    localparam logic [deq_pkg::CMD_W-1:0] CMD_SPARE_HI  = 3'd7;
    localparam int                        STALL_LIMIT   = 1000;
    localparam int                        TAIL_CYCLES   = 8;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_ready;
    deq_pkg::req_t  req       = '0;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    deq_pkg::rsp_t  rsp;

    // predictor copy of the ring
    logic signed [deq_pkg::WORD_W-1:0] ring_mem [deq_pkg::DEPTH];
    int    ring_head = 0;
    int    ring_fill = 0;

    deq_pkg::req_t  pending_cmds [$];
    deq_pkg::rsp_t  expected_rsp [$];

    bit    req_gaps_on  = 1'b1;
    bit    rsp_stalls_on = 1'b1;
    int    req_gap_left   = 0;
    int    rsp_stall_left = 0;

    int    n_errors    = 0;
    int    n_accepted  = 0;
    int    n_checked   = 0;
    int    n_push      = 0;
    int    n_pop       = 0;
    int    n_query     = 0;
    int    n_underflow = 0;
    int    n_overflow  = 0;
    int    idle_run    = 0;

    double_ended_queue_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pick_gap();
        if ($urandom_range(99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [deq_pkg::WORD_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [deq_pkg::CMD_W-1:0] pick_cmd(input int push_pct);
        int r;
        r = $urandom_range(99);
        if (r < push_pct)
            return $urandom_range(1) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT;
        if (r < 94)
            return $urandom_range(1) ? deq_pkg::CMD_POP_BACK : deq_pkg::CMD_POP_FRONT;
        case ($urandom_range(3))
            0:       return CMD_SPARE_LO;
            1:       return CMD_SPARE_MID;
            2:       return CMD_SPARE_HI;
            default: return deq_pkg::CMD_QUERY;
        endcase
    endfunction

    function automatic deq_pkg::rsp_t predict_deq(input deq_pkg::req_t r);
        deq_pkg::rsp_t o;
        int            back_idx;
        o        = '0;
        o.status = deq_pkg::ST_OK;
        case (r.cmd)
            deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK:
            begin
                if (ring_fill >= deq_pkg::DEPTH)
                    o.status = deq_pkg::ST_OVERFLOW;
                else if (r.cmd == deq_pkg::CMD_PUSH_FRONT)
                begin
                    ring_head = (ring_head + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
                    ring_mem[ring_head] = r.value;
                    ring_fill++;
                end
                else
                begin
                    ring_mem[(ring_head + ring_fill) % deq_pkg::DEPTH] = r.value;
                    ring_fill++;
                end
            end
            deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK:
            begin
                if (ring_fill == 0)
                    o.status = deq_pkg::ST_UNDERFLOW;
                else if (r.cmd == deq_pkg::CMD_POP_FRONT)
                begin
                    o.popped_value = ring_mem[ring_head];
                    ring_head = (ring_head + 1) % deq_pkg::DEPTH;
                    ring_fill--;
                end
                else
                begin
                    o.popped_value = ring_mem[(ring_head + ring_fill - 1) % deq_pkg::DEPTH];
                    ring_fill--;
                end
            end
            default: ;
        endcase
        if (ring_fill != 0)
        begin
            back_idx      = (ring_head + ring_fill - 1) % deq_pkg::DEPTH;
            o.front_value = ring_mem[ring_head];
            o.back_value  = ring_mem[back_idx];
        end
        o.is_empty    = (ring_fill == 0);
        o.entry_count = deq_pkg::COUNT_OUT_W'(ring_fill);
        return o;
    endfunction

    task automatic diff_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            n_errors++;
        end
    endtask

    // request driver: one transaction at a time from pending_cmds
    always @(posedge clk)
    begin
        if (rst_n && (!req_valid || req_ready))
        begin
            if (req_gap_left > 0)
            begin
                req_valid    <= 1'b0;
                req_gap_left <= req_gap_left - 1;
            end
            else if (pending_cmds.size() > 0)
            begin
                req          <= pending_cmds[0];
                pending_cmds.delete(0);
                req_valid    <= 1'b1;
                req_gap_left <= (req_gaps_on && $urandom_range(99) < 40) ? pick_gap() : 0;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // response back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_stall_left > 0)
            begin
                rsp_ready      <= 1'b0;
                rsp_stall_left <= rsp_stall_left - 1;
            end
            else if (rsp_stalls_on && $urandom_range(99) < 25)
            begin
                rsp_ready      <= 1'b0;
                rsp_stall_left <= pick_gap() - 1;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // predict on request, compare on response, watchdog
    always @(posedge clk)
    begin : monitor
        deq_pkg::rsp_t want;
        bit            moved;
        moved = 1'b0;
        if (rst_n && req_valid && req_ready)
        begin
            want = predict_deq(req);
            expected_rsp.insert(expected_rsp.size(), want);
            n_accepted++;
            moved = 1'b1;
            case (req.cmd)
                deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: n_push++;
                deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK:   n_pop++;
                default:                                         n_query++;
            endcase
            if (want.status == deq_pkg::ST_UNDERFLOW)
                n_underflow++;
            if (want.status == deq_pkg::ST_OVERFLOW)
                n_overflow++;
        end
        if (rst_n && rsp_valid && rsp_ready)
        begin
            moved = 1'b1;
            if (expected_rsp.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0h", $time, rsp);
                n_errors++;
            end
            else
            begin
                want = expected_rsp[0];
                expected_rsp.delete(0);
                diff_field("popped_value", want.popped_value, rsp.popped_value);
                diff_field("status", 32'(want.status), 32'(rsp.status));
                diff_field("front_value", want.front_value, rsp.front_value);
                diff_field("back_value", want.back_value, rsp.back_value);
                diff_field("is_empty", 32'(want.is_empty), 32'(rsp.is_empty));
                diff_field("entry_count", 32'(want.entry_count), 32'(rsp.entry_count));
                n_checked++;
            end
        end
        idle_run = moved ? 0 : idle_run + 1;
        if (idle_run >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("double_ended_queue_top verification failed");
            $finish;
        end
    end

    task automatic send_cmd(input logic [deq_pkg::CMD_W-1:0] c,
                            input logic signed [deq_pkg::WORD_W-1:0] v);
        deq_pkg::req_t item;
        item.cmd   = c;
        item.value = v;
        while (pending_cmds.size() >= 2)
            @(negedge clk);
        pending_cmds.insert(pending_cmds.size(), item);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_cmds.size() != 0 || req_valid || expected_rsp.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed();
        send_cmd(deq_pkg::CMD_QUERY, 32'sh7fffffff);
        send_cmd(deq_pkg::CMD_POP_FRONT, -32'sd1);
        send_cmd(deq_pkg::CMD_POP_BACK, '0);
        send_cmd(CMD_SPARE_LO, 32'sh80000000);
        send_cmd(CMD_SPARE_MID, -32'sd1);
        send_cmd(CMD_SPARE_HI, 32'sh7fffffff);
        send_cmd(deq_pkg::CMD_PUSH_FRONT, 32'sh7fffffff);
        send_cmd(deq_pkg::CMD_PUSH_BACK, 32'sh80000000);
        send_cmd(deq_pkg::CMD_PUSH_FRONT, '0);
        send_cmd(deq_pkg::CMD_PUSH_BACK, -32'sd1);
        send_cmd(deq_pkg::CMD_QUERY, '0);
        send_cmd(CMD_SPARE_HI, '0);
        send_cmd(deq_pkg::CMD_POP_BACK, '0);
        send_cmd(deq_pkg::CMD_POP_FRONT, '0);
        send_cmd(deq_pkg::CMD_POP_FRONT, '0);
        send_cmd(deq_pkg::CMD_POP_BACK, '0);
        send_cmd(deq_pkg::CMD_POP_BACK, '0);
        send_cmd(deq_pkg::CMD_POP_FRONT, '0);
        send_cmd(deq_pkg::CMD_QUERY, '0);
    endtask

    // fill past capacity from both ends, then empty past zero
    task automatic test_full_overflow();
        for (int i = 0; i < deq_pkg::DEPTH + 4; i++)
            send_cmd((i % 2) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT, pick_value());
        send_cmd(deq_pkg::CMD_QUERY, '0);
        for (int i = 0; i < deq_pkg::DEPTH + 4; i++)
            send_cmd((i % 3 == 0) ? deq_pkg::CMD_POP_BACK : deq_pkg::CMD_POP_FRONT, '0);
    endtask

    // move the head all the way round the ring in both directions
    task automatic test_wrap_around();
        for (int i = 0; i < 3; i++)
            send_cmd(deq_pkg::CMD_PUSH_BACK, pick_value());
        for (int i = 0; i < 2 * deq_pkg::DEPTH; i++)
        begin
            send_cmd(deq_pkg::CMD_PUSH_FRONT, pick_value());
            send_cmd(deq_pkg::CMD_POP_BACK, '0);
        end
        for (int i = 0; i < 2 * deq_pkg::DEPTH; i++)
        begin
            send_cmd(deq_pkg::CMD_PUSH_BACK, pick_value());
            send_cmd(deq_pkg::CMD_POP_FRONT, '0);
        end
    endtask

    task automatic test_back_to_back();
        req_gaps_on   = 1'b0;
        rsp_stalls_on = 1'b0;
        for (int i = 0; i < 50; i++)
            send_cmd(pick_cmd(55), pick_value());
        wait_drained();
        req_gaps_on   = 1'b1;
        rsp_stalls_on = 1'b1;
    endtask

    // phases biased toward filling, emptying and balance
    task automatic test_random_mix();
        int push_bias [7] = '{80, 20, 50, 90, 10, 50, 60};
        for (int p = 0; p < 7; p++)
        begin
            for (int i = 0; i < 80; i++)
                send_cmd(pick_cmd(push_bias[p]), pick_value());
            if (p == 3)
                wait_drained();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        wait_drained();
        test_full_overflow();
        test_wrap_around();
        test_back_to_back();
        test_random_mix();
        test_full_overflow();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_rsp.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_rsp.size());
            n_errors++;
        end
        $display("covered %0d commands: %0d push, %0d pop, %0d query or spare code",
                 n_accepted, n_push, n_pop, n_query);
        $display("%0d results compared, %0d underflows and %0d overflows, %0d mismatches",
                 n_checked, n_underflow, n_overflow, n_errors);
        if (n_errors == 0)
            $display("double_ended_queue_top verification clean");
        else
            $display("double_ended_queue_top verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/deq_pkg.sv
rtl/core/deq_ram.sv
rtl/core/deq_ctrl.sv
rtl/core/deq_dp.sv
rtl/core/double_ended_queue_top.sv
tb/tb.sv
